>>> hdl/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every edge out of reset.
`define ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");

// Same-cycle implication.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`endif

>>> hdl/med_pkg.sv
`timescale 1ns / 1ps
package med_pkg;

    localparam logic [1:0] EL_DIT       = 2'd0;
    localparam logic [1:0] EL_DAH       = 2'd1;
    localparam logic [1:0] EL_CHAR_GAP  = 2'd2;
    localparam logic [1:0] EL_WORD_GAP  = 2'd3;

    localparam logic [2:0] MAX_ELEMENTS    = 3'd6;
    localparam logic [5:0] RECORD_CAPACITY = 6'd38;
    localparam int         NUM_SYMBOLS     = 38;

    typedef struct packed {
        logic [6:0] code;
        logic [2:0] len;
        logic [5:0] bits;
    } t_sym;

    // LSB first, 1 is a dah
    localparam t_sym SYM_TABLE [NUM_SYMBOLS] = '{
        '{7'h41, 3'd2, 6'h02}, '{7'h42, 3'd4, 6'h01}, '{7'h43, 3'd4, 6'h05},
        '{7'h44, 3'd3, 6'h01}, '{7'h45, 3'd1, 6'h00}, '{7'h46, 3'd4, 6'h04},
        '{7'h47, 3'd3, 6'h03}, '{7'h48, 3'd4, 6'h00}, '{7'h49, 3'd2, 6'h00},
        '{7'h4A, 3'd4, 6'h0E}, '{7'h4B, 3'd3, 6'h05}, '{7'h4C, 3'd4, 6'h02},
        '{7'h4D, 3'd2, 6'h03}, '{7'h4E, 3'd2, 6'h01}, '{7'h4F, 3'd3, 6'h07},
        '{7'h50, 3'd4, 6'h06}, '{7'h51, 3'd4, 6'h0B}, '{7'h52, 3'd3, 6'h02},
        '{7'h53, 3'd3, 6'h00}, '{7'h54, 3'd1, 6'h01}, '{7'h55, 3'd3, 6'h04},
        '{7'h56, 3'd4, 6'h08}, '{7'h57, 3'd3, 6'h06}, '{7'h58, 3'd4, 6'h09},
        '{7'h59, 3'd4, 6'h0D}, '{7'h5A, 3'd4, 6'h03},
        '{7'h30, 3'd5, 6'h1F}, '{7'h31, 3'd5, 6'h1E}, '{7'h32, 3'd5, 6'h1C},
        '{7'h33, 3'd5, 6'h18}, '{7'h34, 3'd5, 6'h10}, '{7'h35, 3'd5, 6'h00},
        '{7'h36, 3'd5, 6'h01}, '{7'h37, 3'd5, 6'h03}, '{7'h38, 3'd5, 6'h07},
        '{7'h39, 3'd5, 6'h0F},
        '{7'h2F, 3'd5, 6'h09}, '{7'h3F, 3'd6, 6'h0C}
    };

    // Parallel compare against every entry; 0 means no match.
    function automatic logic [6:0] match_symbol(input logic [5:0] bits, input logic [2:0] len);
        logic [6:0] code;
        code = 7'd0;
        for (int i = 0; i < NUM_SYMBOLS; i++) begin
            if (SYM_TABLE[i].len == len && SYM_TABLE[i].bits == bits) begin
                code = SYM_TABLE[i].code;
            end
        end
        return code;
    endfunction

endpackage

>>> hdl/morse_element_decoder.sv
`timescale 1ns / 1ps
// channel | signals                                   | dir
// element | i_valid, o_ready, i_element               | in
// char    | o_valid, i_ready, o_character,             | out
//         | o_space_before, o_to_record, o_record_slot |
// config  | i_cfg_we, i_cfg_wdata                      | in
//
// One word per cycle while the result is not stalled; a result passes through the
// input register, then is decoded into the result register.
// Synchronous active-low reset clears recording, the decoder and record count.
// A stalled result holds the decode stage; the input register still takes one
// more word, after which o_ready drops.
// A config write clears the pattern, the pending space and the record count.
`include "assert_macros.svh"

module morse_element_decoder (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic [1:0]               i_element,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic [6:0]               o_character,
    output logic                     o_space_before,
    output logic                     o_to_record,
    output logic [5:0]               o_record_slot,
    input  logic                     i_cfg_we,
    input  logic                     i_cfg_wdata
);
    import med_pkg::*;

    logic       r_recording;
    logic [5:0] r_pattern;
    logic [2:0] r_count;
    logic       r_space;
    logic [5:0] r_record_count;

    logic       r_in_valid;
    logic [1:0] r_in_element;

    logic       r_out_valid;
    logic [6:0] r_character;
    logic       r_space_before;
    logic       r_to_record;
    logic [5:0] r_record_slot;

    logic       n_recording;
    logic [5:0] n_pattern;
    logic [2:0] n_count;
    logic       n_space;
    logic [5:0] n_record_count;
    logic       n_emit;
    logic [6:0] n_character;
    logic       n_to_record;
    logic [5:0] n_record_slot;

    logic       out_free;
    logic       advance;
    logic [6:0] match_code;

    assign out_free = !r_out_valid || i_ready;
    assign advance  = r_in_valid && out_free;
    assign o_ready  = !r_in_valid || out_free;

    assign match_code = match_symbol(r_pattern, r_count);

    always_comb begin
        n_recording    = r_recording;
        n_pattern      = r_pattern;
        n_count        = r_count;
        n_space        = r_space;
        n_record_count = r_record_count;
        n_emit         = 1'b0;
        n_character    = match_code;
        n_to_record    = r_recording;
        n_record_slot  = r_recording ? r_record_count : 6'd0;
        if (i_cfg_we) begin
            n_recording    = i_cfg_wdata;
            n_pattern      = 6'd0;
            n_count        = 3'd0;
            n_space        = 1'b0;
            n_record_count = 6'd0;
        end else if (advance) begin
            case (r_in_element)
                EL_DIT, EL_DAH: begin
                    if (r_count < MAX_ELEMENTS) begin
                        if (r_in_element == EL_DAH) begin
                            n_pattern[r_count] = 1'b1;
                        end
                        n_count = r_count + 3'd1;
                    end
                end
                EL_CHAR_GAP: begin
                    if (r_count != 3'd0) begin
                        if (match_code != 7'd0) begin
                            if (!r_recording) begin
                                n_emit = 1'b1;
                            end else if (r_record_count < RECORD_CAPACITY) begin
                                n_emit         = 1'b1;
                                n_record_count = r_record_count + 6'd1;
                            end
                        end
                        n_pattern = 6'd0;
                        n_count   = 3'd0;
                        n_space   = 1'b0;
                    end
                end
                EL_WORD_GAP: begin
                    n_pattern = 6'd0;
                    n_count   = 3'd0;
                    n_space   = 1'b1;
                end
                default: begin
                    n_pattern = r_pattern;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_recording    <= 1'b0;
            r_pattern      <= 6'd0;
            r_count        <= 3'd0;
            r_space        <= 1'b0;
            r_record_count <= 6'd0;
            r_in_valid     <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            r_recording    <= n_recording;
            r_pattern      <= n_pattern;
            r_count        <= n_count;
            r_space        <= n_space;
            r_record_count <= n_record_count;
            if (o_ready) begin
                r_in_valid <= i_valid;
            end
            if (out_free) begin
                r_out_valid <= advance && n_emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_element <= i_element;
        end
        if (advance && n_emit) begin
            r_character    <= n_character;
            r_space_before <= r_space;
            r_to_record    <= n_to_record;
            r_record_slot  <= n_record_slot;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_character    = r_character;
    assign o_space_before = r_space_before;
    assign o_to_record    = r_to_record;
    assign o_record_slot  = r_record_slot;

    `ASSERT_ALWAYS(a_count_max, i_clk, i_rst_n, r_count <= MAX_ELEMENTS)
    `ASSERT_ALWAYS(a_record_max, i_clk, i_rst_n, r_record_count <= RECORD_CAPACITY)
    `ASSERT_IMPLIES(a_empty_pattern, i_clk, i_rst_n, r_count == 3'd0, r_pattern == 6'd0)
    `ASSERT_IMPLIES(a_display_slot, i_clk, i_rst_n, o_valid && !o_to_record, o_record_slot == 6'd0)

endmodule
